@@ rtl/pcps_pkg.sv @@
// Shared types, widths and constants for the particle cell pair scatter block.
`default_nettype none
package pcps_pkg;

    localparam int unsigned DEF_DIMS     = 3;
    localparam int unsigned DEF_GRID_Y   = 64;
    localparam int unsigned DEF_GRID_Z   = 64;
    localparam int unsigned DEF_MAX_SPAN = 4;
    localparam int unsigned MAX_RESULTS  = 64;

    localparam int unsigned COORD_W    = 32;
    localparam int unsigned WID_W      = 31;
    localparam int unsigned SLAB_W     = 7;
    localparam int unsigned LO_W       = 13;
    localparam int unsigned NUM_W      = 34;
    localparam int unsigned MAG_W      = 33;
    localparam int unsigned QUO_W      = 35;
    localparam int unsigned MUL_W      = LO_W + 1 + WID_W;
    localparam int unsigned D_W        = 47;
    localparam int unsigned DSQ_W      = 64;
    localparam int unsigned CELL_W     = 18;
    localparam int unsigned TAG_W      = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_ORIGIN_Z  = 3'd2,
        CFG_WIDTH_X   = 3'd3,
        CFG_WIDTH_Y   = 3'd4,
        CFG_WIDTH_Z   = 3'd5,
        CFG_SLAB_LOW  = 3'd6,
        CFG_SLAB_HIGH = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic       div_side;
        logic       div_store;
        logic       clip;
        logic       sq_mul;
        logic       sq_add;
        logic       sq0;
        logic       sq1;
        logic       sq2;
        logic       emit_init;
        logic       emit;
        logic       over_load;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic any_empty;
        logic any_over;
        logic sq_last;
        logic emit_last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

@@ rtl/pcps_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, floor or ceiling rounding.
`default_nettype none
module pcps_div
    import pcps_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic                     i_ceil,
    input  wire logic signed [NUM_W-1:0]  i_num,
    input  wire logic        [WID_W-1:0]  i_den,
    output logic                          o_done,
    output logic signed [QUO_W-1:0]       o_quo
);
    logic             r_busy, n_busy;
    logic [5:0]       r_cnt, n_cnt;
    logic [MAG_W-1:0] r_quo, n_quo;
    logic [WID_W-1:0] r_rem, n_rem;
    logic [WID_W-1:0] r_den;
    logic             r_neg, r_ceil;
    logic [WID_W:0]   trial;
    logic [WID_W:0]   diff;
    logic             nz;
    logic [QUO_W-1:0] mag;

    assign trial = {r_rem, r_quo[MAG_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign o_done = r_busy && (r_cnt == 6'd0);

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'(MAG_W);
            n_quo  = i_num[NUM_W-1] ? MAG_W'(-i_num) : MAG_W'(i_num);
            n_rem  = '0;
        end else if (r_busy) begin
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 6'd1;
                if (!diff[WID_W]) begin
                    n_rem = diff[WID_W-1:0];
                    n_quo = {r_quo[MAG_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[WID_W-1:0];
                    n_quo = {r_quo[MAG_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_den  <= i_den;
            r_neg  <= i_num[NUM_W-1];
            r_ceil <= i_ceil;
        end
    end

    // truncated magnitude, then round toward the requested side
    always_comb begin
        nz  = (r_rem != '0);
        mag = QUO_W'(r_quo);
        if (r_neg) begin
            o_quo = (!r_ceil && nz) ? -(signed'(mag) + 1) : -signed'(mag);
        end else begin
            o_quo = (r_ceil && nz) ? signed'(mag) + 1 : signed'(mag);
        end
    end
endmodule
`default_nettype wire

@@ rtl/pcps_ctrl.sv @@
// Sequencer: divisions per axis, clipping, distance tables, then pair emission or a single overflow word.
`default_nettype none
module pcps_ctrl
    import pcps_pkg::*;
#(
    parameter int unsigned DIMS = DEF_DIMS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    localparam logic [1:0] AXIS_LAST = 2'(DIMS - 1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DIV   = 12'b0000_0000_0010,
        S_DIVW  = 12'b0000_0000_0100,
        S_CLIP  = 12'b0000_0000_1000,
        S_CHECK = 12'b0000_0001_0000,
        S_OVER  = 12'b0000_0010_0000,
        S_MUL   = 12'b0000_0100_0000,
        S_ADD   = 12'b0000_1000_0000,
        S_SQ0   = 12'b0001_0000_0000,
        S_SQ1   = 12'b0010_0000_0000,
        S_SQ2   = 12'b0100_0000_0000,
        S_EMIT  = 12'b1000_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic       r_side, n_side;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_side  = r_side;
        o_cmd   = '0;
        o_cmd.axis     = r_axis;
        o_cmd.div_side = r_side;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_axis  = '0;
                    n_side  = 1'b0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (i_stat.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_side  = ~r_side;
                    n_state = r_side ? S_CLIP : S_DIV;
                end
            end
            S_CLIP: begin
                o_cmd.clip = 1'b1;
                if (r_axis == AXIS_LAST) begin
                    n_state = S_CHECK;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_DIV;
                end
            end
            S_CHECK: begin
                n_axis = '0;
                if (i_stat.any_empty) begin
                    n_state = S_IDLE;
                end else if (i_stat.any_over) begin
                    n_state = S_OVER;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_OVER: begin
                if (i_stat.out_free) begin
                    o_cmd.over_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.sq_mul = 1'b1;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.sq_add = 1'b1;
                n_state = S_SQ0;
            end
            S_SQ0: begin
                o_cmd.sq0 = 1'b1;
                n_state = S_SQ1;
            end
            S_SQ1: begin
                o_cmd.sq1 = 1'b1;
                n_state = S_SQ2;
            end
            S_SQ2: begin
                o_cmd.sq2 = 1'b1;
                if (!i_stat.sq_last) begin
                    n_state = S_SQ0;
                end else if (r_axis == AXIS_LAST) begin
                    o_cmd.emit_init = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= '0;
            r_side  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_side  <= n_side;
        end
    end
endmodule
`default_nettype wire

@@ rtl/pcps_datapath.sv @@
// Datapath: configuration, range bounds, per-axis distance tables, output word register.
`default_nettype none
module pcps_datapath
    import pcps_pkg::*;
#(
    parameter int unsigned DIMS     = DEF_DIMS,
    parameter int unsigned GRID_Y   = DEF_GRID_Y,
    parameter int unsigned GRID_Z   = DEF_GRID_Z,
    parameter int unsigned MAX_SPAN = DEF_MAX_SPAN
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic signed [COORD_W-1:0]   i_pos_x,
    input  wire logic signed [COORD_W-1:0]   i_pos_y,
    input  wire logic signed [COORD_W-1:0]   i_pos_z,
    input  wire logic [WID_W-1:0]            i_reach,
    input  wire logic [TAG_W-1:0]            i_particle_index,
    input  wire t_cmd                        i_cmd,
    output t_stat                            o_stat,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [CELL_W-1:0]                o_cell_index,
    output logic [DSQ_W-1:0]                 o_dist_sq,
    output logic [TAG_W-1:0]                 o_particle_tag,
    output logic                             o_last_pair,
    output logic                             o_span_overflow
);
    localparam int unsigned SPAN_W  = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam int unsigned CNT_W   = $clog2(MAX_SPAN + 1);
    localparam int unsigned TOT_W   = 3 * CNT_W;
    localparam int unsigned STRIDE1 = (DIMS == 3) ? GRID_Z : 1;
    localparam int unsigned STRIDE0 = GRID_Y * STRIDE1;
    localparam int unsigned STRIDE2 = (DIMS == 3) ? 1 : 0;
    localparam logic [CELL_W-1:0] ST0 = CELL_W'(STRIDE0);
    localparam logic [CELL_W-1:0] ST1 = CELL_W'(STRIDE1);
    localparam logic [CELL_W-1:0] ST2 = CELL_W'(STRIDE2);

    // configuration
    logic signed [COORD_W-1:0] r_org [3];
    logic [WID_W-1:0]          r_wid [3];
    logic [SLAB_W-1:0]         r_slab_lo, r_slab_hi;
    logic [WID_W-1:0]          cfg_w;

    assign cfg_w = (i_cfg_data[WID_W-1:0] == '0) ? WID_W'(1) : i_cfg_data[WID_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0]  <= '0;
            r_org[1]  <= '0;
            r_org[2]  <= '0;
            r_wid[0]  <= WID_W'(65536);
            r_wid[1]  <= WID_W'(65536);
            r_wid[2]  <= WID_W'(65536);
            r_slab_lo <= '0;
            r_slab_hi <= SLAB_W'(64);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X:  r_org[0]  <= signed'(i_cfg_data);
                CFG_ORIGIN_Y:  r_org[1]  <= signed'(i_cfg_data);
                CFG_ORIGIN_Z:  r_org[2]  <= signed'(i_cfg_data);
                CFG_WIDTH_X:   r_wid[0]  <= cfg_w;
                CFG_WIDTH_Y:   r_wid[1]  <= cfg_w;
                CFG_WIDTH_Z:   r_wid[2]  <= cfg_w;
                CFG_SLAB_LOW:  r_slab_lo <= i_cfg_data[SLAB_W-1:0];
                CFG_SLAB_HIGH: r_slab_hi <= i_cfg_data[SLAB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // particle capture
    logic signed [COORD_W-1:0] r_pos [3];
    logic [WID_W-1:0]          r_reach;
    logic [TAG_W-1:0]          r_tag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos[0] <= i_pos_x;
            r_pos[1] <= i_pos_y;
            r_pos[2] <= i_pos_z;
            r_reach  <= i_reach;
            r_tag    <= i_particle_index;
        end
    end

    // range bounds through the shared divider
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] p_ext, o_ext, r_ext;
    logic                    div_done;
    logic signed [QUO_W-1:0] div_quo;

    assign p_ext = NUM_W'(r_pos[i_cmd.axis]);
    assign o_ext = NUM_W'(r_org[i_cmd.axis]);
    assign r_ext = signed'(NUM_W'(r_reach));
    assign num   = i_cmd.div_side ? (p_ext + r_ext - o_ext) : (p_ext - r_ext - o_ext);

    pcps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_ceil  (i_cmd.div_side),
        .i_num   (num),
        .i_den   (r_wid[i_cmd.axis]),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    logic signed [QUO_W-1:0] r_qlo, r_qhi;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            if (i_cmd.div_side) begin
                r_qhi <= div_quo;
            end else begin
                r_qlo <= div_quo;
            end
        end
    end

    // clip to slab or grid
    logic signed [QUO_W-1:0] fb, cb, lc, hc, span;
    logic                    clip_empty, clip_over;
    logic [LO_W-1:0]         r_lo  [3];
    logic [CNT_W-1:0]        r_cnt [3];
    logic                    r_empty, r_over;

    always_comb begin
        fb = (i_cmd.axis == 2'd0) ? signed'(QUO_W'(r_slab_lo)) : '0;
        case (i_cmd.axis)
            2'd0:    cb = signed'(QUO_W'(r_slab_hi));
            2'd1:    cb = signed'(QUO_W'(GRID_Y));
            default: cb = signed'(QUO_W'(GRID_Z));
        endcase
        lc = (r_qlo < fb) ? fb : r_qlo;
        hc = (r_qhi > cb) ? cb : r_qhi;
        span = hc - lc;
        clip_empty = (hc <= lc);
        clip_over  = (span > signed'(QUO_W'(MAX_SPAN)));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_empty <= 1'b0;
            r_over  <= 1'b0;
        end else if (i_cmd.clip) begin
            r_empty <= r_empty | clip_empty;
            r_over  <= r_over | clip_over;
        end
        if (i_cmd.clip) begin
            r_lo[i_cmd.axis]  <= lc[LO_W-1:0];
            r_cnt[i_cmd.axis] <= span[CNT_W-1:0];
        end
    end

    logic [TOT_W-1:0] total;
    assign total = TOT_W'(r_cnt[0]) * TOT_W'(r_cnt[1])
                 * ((DIMS == 3) ? TOT_W'(r_cnt[2]) : TOT_W'(1));

    // quarter-square tables, one entry per covered row of each axis
    logic [MUL_W-1:0]      r_mul;
    logic signed [D_W-1:0] r_d;
    logic [D_W-1:0]        d_abs;
    logic                  r_sat, r_b;
    logic [31:0]           r_q;
    logic [DSQ_W-1:0]      r_prod;
    logic [SPAN_W-1:0]     r_k;
    logic [DSQ_W-1:0]      r_tab [3][MAX_SPAN];
    logic signed [D_W-1:0] two_o, two_p, two_w;

    assign two_o = signed'({{(D_W-COORD_W-1){r_org[i_cmd.axis][COORD_W-1]}},
                           r_org[i_cmd.axis], 1'b0});
    assign two_p = signed'({{(D_W-COORD_W-1){r_pos[i_cmd.axis][COORD_W-1]}},
                           r_pos[i_cmd.axis], 1'b0});
    assign two_w = signed'(D_W'({r_wid[i_cmd.axis], 1'b0}));
    assign d_abs = r_d[D_W-1] ? D_W'(-r_d) : D_W'(r_d);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_mul) begin
            r_mul <= MUL_W'({r_lo[i_cmd.axis], 1'b1}) * MUL_W'(r_wid[i_cmd.axis]);
            r_k   <= '0;
        end
        if (i_cmd.sq_add) begin
            r_d <= two_o - two_p + signed'(D_W'(r_mul));
        end
        if (i_cmd.sq0) begin
            r_sat <= |d_abs[D_W-1:MAG_W];
            r_q   <= d_abs[MAG_W-1:1];
            r_b   <= d_abs[0];
        end
        if (i_cmd.sq1) begin
            r_prod <= DSQ_W'(r_q) * DSQ_W'(r_q);
        end
        if (i_cmd.sq2) begin
            r_tab[i_cmd.axis][r_k] <= r_sat ? '1 : r_prod + (r_b ? DSQ_W'(r_q) : '0);
            // step the offset to the next cell centre
            r_d <= r_d + two_w;
            r_k <= r_k + SPAN_W'(1);
        end
    end

    // pair emission, last axis fastest
    logic [SPAN_W-1:0] r_e [3];
    logic [2:0]        at_end;
    logic [CELL_W-1:0] jj0, j1, j2, flat;
    logic [DSQ_W:0]    s1, s2;
    logic [DSQ_W-1:0]  a1, t2;

    always_comb begin
        at_end[0] = (CNT_W'(r_e[0]) + CNT_W'(1) == r_cnt[0]);
        at_end[1] = (CNT_W'(r_e[1]) + CNT_W'(1) == r_cnt[1]);
        at_end[2] = (DIMS == 3) ? (CNT_W'(r_e[2]) + CNT_W'(1) == r_cnt[2]) : 1'b1;
        jj0  = CELL_W'(r_lo[0]) + CELL_W'(r_e[0]) - CELL_W'(r_slab_lo);
        j1   = CELL_W'(r_lo[1]) + CELL_W'(r_e[1]);
        j2   = (DIMS == 3) ? CELL_W'(r_lo[2]) + CELL_W'(r_e[2]) : '0;
        flat = jj0 * ST0 + j1 * ST1 + j2 * ST2;
        t2   = (DIMS == 3) ? r_tab[2][r_e[2]] : '0;
        s1   = {1'b0, r_tab[0][r_e[0]]} + {1'b0, r_tab[1][r_e[1]]};
        a1   = s1[DSQ_W] ? '1 : s1[DSQ_W-1:0];
        s2   = {1'b0, a1} + {1'b0, t2};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_init) begin
            r_e[0] <= '0;
            r_e[1] <= '0;
            r_e[2] <= '0;
        end else if (i_cmd.emit) begin
            if (!at_end[2]) begin
                r_e[2] <= r_e[2] + SPAN_W'(1);
            end else begin
                r_e[2] <= '0;
                if (!at_end[1]) begin
                    r_e[1] <= r_e[1] + SPAN_W'(1);
                end else begin
                    r_e[1] <= '0;
                    r_e[0] <= r_e[0] + SPAN_W'(1);
                end
            end
        end
    end

    // output word register
    logic r_ovalid;
    logic out_free;

    assign out_free = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.over_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.emit) begin
            o_cell_index    <= flat;
            o_dist_sq       <= s2[DSQ_W] ? '1 : s2[DSQ_W-1:0];
            o_particle_tag  <= r_tag;
            o_last_pair     <= &at_end;
            o_span_overflow <= 1'b0;
        end else if (i_cmd.over_load) begin
            o_cell_index    <= '0;
            o_dist_sq       <= '0;
            o_particle_tag  <= r_tag;
            o_last_pair     <= 1'b1;
            o_span_overflow <= 1'b1;
        end
    end

    assign o_valid = r_ovalid;

    always_comb begin
        o_stat.div_done  = div_done;
        o_stat.any_empty = r_empty;
        o_stat.any_over  = r_over || (total > TOT_W'(MAX_RESULTS));
        o_stat.sq_last   = (CNT_W'(r_k) + CNT_W'(1) == r_cnt[i_cmd.axis]);
        o_stat.emit_last = &at_end;
        o_stat.out_free  = out_free;
    end
endmodule
`default_nettype wire

@@ rtl/particle_cell_pair_scatter.sv @@
// Top level of the particle cell pair scatter block.
// One particle word in, one output word per grid cell its support touches, last
// axis fastest, last_pair on the final word; a range wider than MAX_SPAN on an axis
// (or more than 64 cells) gives a single word with span_overflow set, an empty range
// gives none. Particles are handled one at a time. The shared 33-step divider sets
// most of the latency: each axis takes two divisions and one clip, then the distance
// tables are built axis by axis, row by row, then one output word is sent per cycle
// while the consumer keeps up. The next particle is taken while the last output
// word still waits.
`default_nettype none
module particle_cell_pair_scatter
    import pcps_pkg::*;
#(
    parameter int unsigned DIMS     = DEF_DIMS,
    parameter int unsigned GRID_Y   = DEF_GRID_Y,
    parameter int unsigned GRID_Z   = DEF_GRID_Z,
    parameter int unsigned MAX_SPAN = DEF_MAX_SPAN
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [COORD_W-1:0] i_pos_x,
    input  wire logic signed [COORD_W-1:0] i_pos_y,
    input  wire logic signed [COORD_W-1:0] i_pos_z,
    input  wire logic [WID_W-1:0]          i_reach,
    input  wire logic [TAG_W-1:0]          i_particle_index,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [CELL_W-1:0]              o_cell_index,
    output logic [DSQ_W-1:0]               o_dist_sq,
    output logic [TAG_W-1:0]               o_particle_tag,
    output logic                           o_last_pair,
    output logic                           o_span_overflow
);
    t_cmd  cmd;
    t_stat stat;

    pcps_ctrl #(
        .DIMS (DIMS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pcps_datapath #(
        .DIMS     (DIMS),
        .GRID_Y   (GRID_Y),
        .GRID_Z   (GRID_Z),
        .MAX_SPAN (MAX_SPAN)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_reach          (i_reach),
        .i_particle_index (i_particle_index),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_cell_index     (o_cell_index),
        .o_dist_sq        (o_dist_sq),
        .o_particle_tag   (o_particle_tag),
        .o_last_pair      (o_last_pair),
        .o_span_overflow  (o_span_overflow)
    );
endmodule
`default_nettype wire

@@ dv/particle_cell_pair_scatter_tb.sv @@
// Self-checking testbench for particle_cell_pair_scatter: random and directed particles, scoreboard.
`timescale 1ns / 1ps
module particle_cell_pair_scatter_tb;
    import pcps_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned SETTLE      = 600;
    localparam int unsigned LONG_HOLD   = 3000;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [WID_W-1:0]          reach;
        logic [TAG_W-1:0]          tag;
    } t_particle;

    typedef struct {
        logic [CELL_W-1:0] cidx;
        logic [DSQ_W-1:0]  dsq;
        logic [TAG_W-1:0]  tag;
        logic              last;
        logic              ovf;
    } t_pair;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      o_ready;
    logic signed [COORD_W-1:0] pos_x = '0;
    logic signed [COORD_W-1:0] pos_y = '0;
    logic signed [COORD_W-1:0] pos_z = '0;
    logic [WID_W-1:0]          reach = '0;
    logic [TAG_W-1:0]          pidx = '0;
    logic                      o_valid;
    logic                      out_ready = 1'b0;
    logic [CELL_W-1:0]         o_cell_index;
    logic [DSQ_W-1:0]          o_dist_sq;
    logic [TAG_W-1:0]          o_particle_tag;
    logic                      o_last_pair;
    logic                      o_span_overflow;

    t_particle pending[$];
    t_pair     pair_queue[$];
    t_particle offered;
    longint    org[3];
    longint    wid[3];
    longint    slab_lo;
    longint    slab_hi;
    int        in_gap = 0;
    int        out_gap = 0;
    int        hold_left = 0;
    bit        quiet = 1'b0;
    bit        stall_go = 1'b0;
    bit        stall_done = 1'b0;
    bit        failed = 1'b0;
    int unsigned cycles = 0;

    particle_cell_pair_scatter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_valid         (in_valid),
        .o_ready         (o_ready),
        .i_pos_x         (pos_x),
        .i_pos_y         (pos_y),
        .i_pos_z         (pos_z),
        .i_reach         (reach),
        .i_particle_index(pidx),
        .o_valid         (o_valid),
        .i_ready         (out_ready),
        .o_cell_index    (o_cell_index),
        .o_dist_sq       (o_dist_sq),
        .o_particle_tag  (o_particle_tag),
        .o_last_pair     (o_last_pair),
        .o_span_overflow (o_span_overflow)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // floor(d*d/4), saturating
    function automatic logic [63:0] quarter_sq(longint d);
        longint unsigned a;
        longint unsigned q;
        a = d < 0 ? -d : d;
        if (a >= (64'd1 << 33)) return '1;
        q = a >> 1;
        return q * q + q * a[0];
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return s < a ? '1 : s;
    endfunction

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if (n % d != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint ceil_div(longint n, longint d);
        longint q;
        q = n / d;
        if (n % d != 0 && n > 0) q++;
        return q;
    endfunction

    // Append the pairs one particle produces under the current register values.
    function automatic void predict_pairs(t_particle p);
        longint pos[3], lo[3], cnt[3], stride[3], j[3];
        longint l, h, fb, cb, r, total, e, d, flat;
        logic [63:0] dsq;
        bit over;
        t_pair w;
        pos[0] = p.x;
        pos[1] = p.y;
        pos[2] = p.z;
        r = longint'(p.reach);
        stride[2] = 1;
        stride[1] = DEF_GRID_Z;
        stride[0] = DEF_GRID_Y * DEF_GRID_Z;
        over = 1'b0;
        for (int a = 0; a < 3; a++) begin
            l = floor_div(pos[a] - r - org[a], wid[a]);
            h = ceil_div(pos[a] + r - org[a], wid[a]);
            fb = a == 0 ? slab_lo : 0;
            cb = a == 0 ? slab_hi : (a == 1 ? DEF_GRID_Y : DEF_GRID_Z);
            if (l < fb) l = fb;
            if (h > cb) h = cb;
            if (h <= l) return;
            lo[a] = l;
            cnt[a] = h - l;
            if (cnt[a] > DEF_MAX_SPAN) over = 1'b1;
        end
        total = cnt[0] * cnt[1] * cnt[2];
        if (total > MAX_RESULTS) over = 1'b1;
        if (over) begin
            w = '{cidx: '0, dsq: '0, tag: p.tag, last: 1'b1, ovf: 1'b1};
            pair_queue.push_back(w);
            return;
        end
        for (e = 0; e < total; e++) begin
            j[2] = lo[2] + e % cnt[2];
            j[1] = lo[1] + (e / cnt[2]) % cnt[1];
            j[0] = lo[0] + e / (cnt[2] * cnt[1]);
            dsq = '0;
            flat = 0;
            for (int a = 0; a < 3; a++) begin
                d = 2 * org[a] + (2 * j[a] + 1) * wid[a] - 2 * pos[a];
                dsq = add_sat(dsq, quarter_sq(d));
                flat += (a == 0 ? j[a] - slab_lo : j[a]) * stride[a];
            end
            w.cidx = flat[CELL_W-1:0];
            w.dsq = dsq;
            w.tag = p.tag;
            w.last = e == total - 1;
            w.ovf = 1'b0;
            pair_queue.push_back(w);
        end
    endfunction

    // Input driver: offer queued particles, predict on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_ready) predict_pairs(offered);
            if (!in_valid || o_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending.size() > 0) begin
                    offered = pending.pop_front();
                    pos_x <= offered.x;
                    pos_y <= offered.y;
                    pos_z <= offered.z;
                    reach <= offered.reach;
                    pidx <= offered.tag;
                    in_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 16);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compare each word with the oldest predicted pair.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_valid && out_ready) begin
                if (pair_queue.size() == 0) begin
                    $error("unexpected word: cell_index %0d", o_cell_index);
                    failed = 1'b1;
                end else begin
                    t_pair x;
                    x = pair_queue.pop_front();
                    if (o_cell_index !== x.cidx) begin
                        $error("cell_index exp %0d got %0d", x.cidx, o_cell_index);
                        failed = 1'b1;
                    end
                    if (o_dist_sq !== x.dsq) begin
                        $error("dist_sq exp %h got %h", x.dsq, o_dist_sq);
                        failed = 1'b1;
                    end
                    if (o_particle_tag !== x.tag) begin
                        $error("particle_tag exp %h got %h", x.tag, o_particle_tag);
                        failed = 1'b1;
                    end
                    if (o_last_pair !== x.last) begin
                        $error("last_pair exp %0d got %0d", x.last, o_last_pair);
                        failed = 1'b1;
                    end
                    if (o_span_overflow !== x.ovf) begin
                        $error("span_overflow exp %0d got %0d", x.ovf, o_span_overflow);
                        failed = 1'b1;
                    end
                end
            end
            if (stall_go && !stall_done) begin
                stall_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0) out_gap = $urandom_range(1, 16);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z: begin
                org[idx] = longint'($signed(data));
            end
            CFG_WIDTH_X, CFG_WIDTH_Y, CFG_WIDTH_Z: begin
                wid[idx - CFG_WIDTH_X] = data[30:0] == 0 ? 1 : longint'(data[30:0]);
            end
            CFG_SLAB_LOW: slab_lo = data[6:0];
            default: slab_hi = data[6:0];
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_particle(longint x, longint y, longint z, longint r, logic [31:0] t);
        t_particle p;
        p.x = x[31:0];
        p.y = y[31:0];
        p.z = z[31:0];
        p.reach = r[30:0];
        p.tag = t;
        pending.push_back(p);
    endtask

    // Mostly particles placed near the grid; some pure noise to toggle every bit.
    task automatic push_random(int n);
        longint c[3], p[3], rmin, r, lo_row;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 6) == 0) begin
                push_particle($urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                lo_row = slab_lo;
                c[0] = lo_row - 2 + $urandom_range(0, 5 + (slab_hi > slab_lo ? slab_hi - slab_lo : 0));
                c[1] = longint'($urandom_range(0, 67)) - 2;
                c[2] = longint'($urandom_range(0, 67)) - 2;
                rmin = wid[0];
                for (int a = 0; a < 3; a++) begin
                    p[a] = org[a] + c[a] * wid[a] + $urandom_range(0, wid[a] - 1);
                    if (wid[a] < rmin) rmin = wid[a];
                end
                r = longint'($urandom_range(0, 3)) * rmin / 2 + $urandom_range(0, 255);
                if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
                push_particle(p[0], p[1], p[2], r, $urandom);
            end
        end
    endtask

    // Wait until every particle is taken and every pair seen, then let the block settle.
    task automatic drain();
        while (pending.size() > 0 || in_valid || pair_queue.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        for (int a = 0; a < 3; a++) begin
            org[a] = 0;
            wid[a] = 65536;
        end
        slab_lo = 0;
        slab_hi = 64;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: cell centre, exact cell edge, span of four, span of six, edges, extremes
        push_particle(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 0, 32'h0);
        push_particle(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 32'hFFFF_FFFF);
        push_particle(32 << 16, 32 << 16, 32 << 16, 2 << 16, 32'h1234_5678);
        push_particle(32 << 16, 32 << 16, 32 << 16, (2 << 16) + 1, 32'h8765_4321);
        push_particle(63 << 16, 63 << 16, 63 << 16, 32'h0001_8000, 32'h5);
        push_particle(-1, -1, -1, 0, 32'h6);
        push_particle(0, 0, 0, 32'h0000_8000, 32'h7);
        push_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8);
        push_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h9);
        push_particle(32'h8000_0000, 5 << 16, 5 << 16, 32'h0000_4000, 32'hA);
        push_particle(10 << 16, 64 << 16, 10 << 16, 0, 32'hB);
        push_particle(10 << 16, 10 << 16, 32'h0040_8000, 32'h0000_9000, 32'hC);
        push_particle(20 << 16, 20 << 16, 20 << 16, 32 << 16, 32'hD);
        push_random(45);
        drain();

        write_reg(CFG_ORIGIN_X, -(8 << 16));
        write_reg(CFG_ORIGIN_Y, (3 << 16) + 123);
        write_reg(CFG_ORIGIN_Z, 32'h0000_7777);
        write_reg(CFG_WIDTH_X, 32'h0001_8000);
        write_reg(CFG_WIDTH_Y, 32'h0000_8000);
        write_reg(CFG_WIDTH_Z, 32'h0002_0000);
        write_reg(CFG_SLAB_LOW, 5);
        write_reg(CFG_SLAB_HIGH, 37);
        // keep offering while the receiver holds off, so the block backs up
        stall_go = 1'b1;
        push_particle(20 << 16, 10 << 16, 10 << 16, 32'h0001_0000, 32'h100);
        push_random(45);
        drain();

        // extremes: min/max origins, zero and max widths, slab beyond the grid
        write_reg(CFG_ORIGIN_X, 32'h8000_0000);
        write_reg(CFG_ORIGIN_Y, 32'h7FFF_FFFF);
        write_reg(CFG_ORIGIN_Z, 32'h8000_0000);
        write_reg(CFG_WIDTH_X, 32'h0);
        write_reg(CFG_WIDTH_Y, 32'h7FFF_FFFF);
        write_reg(CFG_WIDTH_Z, 32'h1);
        write_reg(CFG_SLAB_LOW, 60);
        write_reg(CFG_SLAB_HIGH, 127);
        push_random(30);
        drain();

        // inverted slab gives nothing
        write_reg(CFG_SLAB_LOW, 64);
        write_reg(CFG_SLAB_HIGH, 0);
        push_random(8);
        drain();

        write_reg(CFG_ORIGIN_X, 32'h0);
        write_reg(CFG_ORIGIN_Y, 32'hFFFF_0000);
        write_reg(CFG_ORIGIN_Z, 32'h0003_0000);
        write_reg(CFG_WIDTH_X, 32'h7FFF_FFFF);
        write_reg(CFG_WIDTH_Y, 32'h0001_0000);
        write_reg(CFG_WIDTH_Z, 32'h0000_C000);
        write_reg(CFG_SLAB_LOW, 0);
        write_reg(CFG_SLAB_HIGH, 1);
        push_random(15);
        drain();

        // last stretch at full rate
        write_reg(CFG_WIDTH_X, 32'h0001_0000);
        write_reg(CFG_SLAB_HIGH, 64);
        quiet = 1'b1;
        push_random(30);
        drain();

        if (!failed) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
